@@ design/lrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and constants of the link reconnect supervisor: event codes,
// link states, command codes, register map and the reconnect delay math.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int BASE_W  = 22;
    localparam int DELAY_W = 27;
    localparam int CNT_W   = 8;
    localparam int STEP_W  = 3;
    localparam int JIT_W   = 6;
    localparam int SCALE_W = 7;
    localparam int PROD_W  = 34;
    localparam int PADDR_W = 4;

    typedef enum logic [2:0] {
        CMD_NET_UP          = 3'd0,
        CMD_NET_DOWN        = 3'd1,
        CMD_GATE_TICK       = 3'd2,
        CMD_SOCK_OPEN       = 3'd3,
        CMD_SOCK_LOST       = 3'd4,
        CMD_WELCOME         = 3'd5,
        CMD_WELCOME_TIMEOUT = 3'd6,
        CMD_ATTEMPT         = 3'd7
    } cmd_t;

    typedef enum logic [3:0] {
        LINK_WAIT_NET  = 4'b0001,
        LINK_WAIT_GATE = 4'b0010,
        LINK_READY     = 4'b0100,
        LINK_CONNECTED = 4'b1000
    } link_t;

    // Link state codes as seen on the result channel.
    localparam logic [1:0] LS_WAIT_NET  = 2'd0;
    localparam logic [1:0] LS_WAIT_GATE = 2'd1;
    localparam logic [1:0] LS_READY     = 2'd2;
    localparam logic [1:0] LS_CONNECTED = 2'd3;

    localparam logic [1:0] NTF_NONE       = 2'd0;
    localparam logic [1:0] NTF_WAITING    = 2'd1;
    localparam logic [1:0] NTF_CONNECTING = 2'd2;
    localparam logic [1:0] NTF_READY      = 2'd3;

    localparam logic [1:0] TMR_NONE  = 2'd0;
    localparam logic [1:0] TMR_START = 2'd1;
    localparam logic [1:0] TMR_STOP  = 2'd2;

    localparam logic [1:0] REG_SOCK_FAIL_LIMIT = 2'd0;
    localparam logic [1:0] REG_NET_RESET_LIMIT = 2'd1;
    localparam logic [1:0] REG_BASE_DELAY      = 2'd2;
    localparam logic [1:0] REG_MAX_DELAY       = 2'd3;

    localparam logic [CNT_W-1:0]   RST_SOCK_FAIL_LIMIT = 8'd8;
    localparam logic [CNT_W-1:0]   RST_NET_RESET_LIMIT = 8'd3;
    localparam logic [BASE_W-1:0]  RST_BASE_DELAY      = 22'd3000000;
    localparam logic [DELAY_W-1:0] RST_MAX_DELAY       = 27'd60000000;

    localparam logic [STEP_W-1:0]  BACKOFF_CAP = 3'd5;
    localparam logic [STEP_W-1:0]  BACKOFF_MAX = 3'd7;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 8'd255;
    localparam logic [JIT_W-1:0]   JITTER_MOD  = 6'd41;
    localparam logic [SCALE_W-1:0] JITTER_BASE = 7'd80;
    localparam logic [DELAY_W-1:0] DELAY_MAX   = 27'h7FFFFFF;

    // Division by 100 is a shift by two followed by x / 25, done as
    // x * ceil(2^37 / 25) >> 37, which is exact for any 32-bit x.
    localparam int          RECIP_W     = 33;
    localparam int          RECIP_SHIFT = 37;
    localparam logic [32:0] RECIP_25    = 33'd5497558139;

    typedef struct packed {
        logic [CNT_W-1:0]   sock_fail_limit;
        logic [CNT_W-1:0]   net_reset_limit;
        logic [BASE_W-1:0]  base_delay_us;
        logic [DELAY_W-1:0] max_delay_us;
    } cfg_t;

    typedef struct packed {
        logic [1:0] link_state;
        logic       session_up;
        logic [1:0] notify_code;
        logic       arm_reconnect;
        logic [1:0] welcome_timer_cmd;
        logic [1:0] gate_timer_cmd;
        logic       open_socket;
        logic       close_socket;
        logic       net_reset_req;
        logic       restart_req;
        logic       flush_outbox;
    } res_ctl_t;

    typedef struct packed {
        res_ctl_t           ctl;
        logic [DELAY_W-1:0] delay_base;
        logic [SCALE_W-1:0] scale;
    } stage1_t;

    function automatic logic [1:0] link_code(link_t mode);
        logic [1:0] code;
        case (mode)
            LINK_WAIT_NET:  code = LS_WAIT_NET;
            LINK_WAIT_GATE: code = LS_WAIT_GATE;
            LINK_READY:     code = LS_READY;
            LINK_CONNECTED: code = LS_CONNECTED;
            default:        code = LS_WAIT_NET;
        endcase
        return code;
    endfunction

endpackage

@@ design/lrs_evt_if.sv @@
// ----------------------------------------------------------------------------
// lrs_evt_if
// Event channel of the link reconnect supervisor: one event per beat.
// ----------------------------------------------------------------------------
interface lrs_evt_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic       gate_ok;
    logic       start_ok;
    logic [5:0] jitter;

    modport source (output valid, command, gate_ok, start_ok, jitter, input ready);
    modport sink   (input valid, command, gate_ok, start_ok, jitter, output ready);
endinterface

@@ design/lrs_res_if.sv @@
// ----------------------------------------------------------------------------
// lrs_res_if
// Result channel of the link reconnect supervisor: one result per beat.
// ----------------------------------------------------------------------------
interface lrs_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  link_state;
    logic        session_up;
    logic [1:0]  notify_code;
    logic        arm_reconnect;
    logic [26:0] reconnect_delay_us;
    logic [1:0]  welcome_timer_cmd;
    logic [1:0]  gate_timer_cmd;
    logic        open_socket;
    logic        close_socket;
    logic        net_reset_req;
    logic        restart_req;
    logic        flush_outbox;

    modport source (
        output valid, link_state, session_up, notify_code, arm_reconnect,
               reconnect_delay_us, welcome_timer_cmd, gate_timer_cmd, open_socket,
               close_socket, net_reset_req, restart_req, flush_outbox,
        input  ready
    );
    modport sink (
        input  valid, link_state, session_up, notify_code, arm_reconnect,
               reconnect_delay_us, welcome_timer_cmd, gate_timer_cmd, open_socket,
               close_socket, net_reset_req, restart_req, flush_outbox,
        output ready
    );
endinterface

@@ design/lrs_cfg.sv @@
// ----------------------------------------------------------------------------
// lrs_cfg
// APB register file holding the failure limits and the reconnect delay
// settings.
// ----------------------------------------------------------------------------
module lrs_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lrs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output lrs_pkg::cfg_t               cfg
);

    lrs_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sock_fail_limit <= lrs_pkg::RST_SOCK_FAIL_LIMIT;
            cfg_reg.net_reset_limit <= lrs_pkg::RST_NET_RESET_LIMIT;
            cfg_reg.base_delay_us   <= lrs_pkg::RST_BASE_DELAY;
            cfg_reg.max_delay_us    <= lrs_pkg::RST_MAX_DELAY;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                lrs_pkg::REG_SOCK_FAIL_LIMIT: cfg_reg.sock_fail_limit <= pwdata[7:0];
                lrs_pkg::REG_NET_RESET_LIMIT: cfg_reg.net_reset_limit <= pwdata[7:0];
                lrs_pkg::REG_BASE_DELAY:      cfg_reg.base_delay_us   <= pwdata[21:0];
                lrs_pkg::REG_MAX_DELAY:       cfg_reg.max_delay_us    <= pwdata[26:0];
                default:                      cfg_reg.max_delay_us    <= cfg_reg.max_delay_us;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lrs_pkg::REG_SOCK_FAIL_LIMIT: prdata = {24'd0, cfg_reg.sock_fail_limit};
            lrs_pkg::REG_NET_RESET_LIMIT: prdata = {24'd0, cfg_reg.net_reset_limit};
            lrs_pkg::REG_BASE_DELAY:      prdata = {10'd0, cfg_reg.base_delay_us};
            lrs_pkg::REG_MAX_DELAY:       prdata = {5'd0, cfg_reg.max_delay_us};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

@@ design/lrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrs_ctrl
// Input register and link state machine. Each event updates the link state,
// flags, backoff level and failure counters and registers the
// commands together with the clipped delay and the jitter scale.
// ----------------------------------------------------------------------------
module lrs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  lrs_pkg::cfg_t    cfg,
    lrs_evt_if.sink          evt,
    output logic             st1_valid,
    output lrs_pkg::stage1_t st1
);

    logic                        evt_valid_reg;
    lrs_pkg::cmd_t               cmd_reg;
    logic                        gate_ok_reg;
    logic                        start_ok_reg;
    logic [lrs_pkg::JIT_W-1:0]   jitter_reg;

    lrs_pkg::link_t              mode_reg, mode_next;
    logic                        sess_reg, sess_next;
    logic                        drop_reg, drop_next;
    logic [lrs_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [lrs_pkg::CNT_W-1:0]   fail_reg, fail_next;
    logic [lrs_pkg::CNT_W-1:0]   rcnt_reg, rcnt_next;

    logic                        st1_valid_reg;
    lrs_pkg::stage1_t            st1_reg, st1_next;

    logic [lrs_pkg::CNT_W-1:0]   fail_inc;
    logic [lrs_pkg::CNT_W-1:0]   rcnt_inc;
    logic [lrs_pkg::STEP_W-1:0]  step_bump;
    logic [lrs_pkg::STEP_W-1:0]  shift_amt;
    logic [lrs_pkg::DELAY_W-1:0] shifted;
    logic [lrs_pkg::DELAY_W-1:0] clipped;
    logic [lrs_pkg::SCALE_W-1:0] jit_mod;
    logic                        arm;

    assign evt.ready = advance;
    assign st1_valid = st1_valid_reg;
    assign st1       = st1_reg;

    assign fail_inc  = (fail_reg == lrs_pkg::CNT_MAX) ? fail_reg : fail_reg + 8'd1;
    assign rcnt_inc  = (rcnt_reg == lrs_pkg::CNT_MAX) ? rcnt_reg : rcnt_reg + 8'd1;
    assign step_bump = (step_reg == lrs_pkg::BACKOFF_MAX) ? step_reg : step_reg + 3'd1;

    always_comb
    begin
        mode_next = mode_reg;
        sess_next = sess_reg;
        drop_next = drop_reg;
        step_next = step_reg;
        fail_next = fail_reg;
        rcnt_next = rcnt_reg;
        st1_next  = '0;
        arm       = 1'b0;

        case (cmd_reg)
            lrs_pkg::CMD_NET_UP:
            begin
                if (mode_reg == lrs_pkg::LINK_WAIT_NET)
                begin
                    mode_next                  = lrs_pkg::LINK_WAIT_GATE;
                    st1_next.ctl.gate_timer_cmd = lrs_pkg::TMR_START;
                    if (gate_ok_reg)
                    begin
                        // The gate is already open: the poll timer stops at once.
                        st1_next.ctl.gate_timer_cmd = lrs_pkg::TMR_STOP;
                        mode_next                   = lrs_pkg::LINK_READY;
                        st1_next.ctl.notify_code    = lrs_pkg::NTF_CONNECTING;
                        arm                         = 1'b1;
                    end
                end
            end
            lrs_pkg::CMD_GATE_TICK:
            begin
                if (mode_reg != lrs_pkg::LINK_WAIT_GATE)
                begin
                    st1_next.ctl.gate_timer_cmd = lrs_pkg::TMR_STOP;
                end
                else if (gate_ok_reg)
                begin
                    st1_next.ctl.gate_timer_cmd = lrs_pkg::TMR_STOP;
                    mode_next                   = lrs_pkg::LINK_READY;
                    st1_next.ctl.notify_code    = lrs_pkg::NTF_CONNECTING;
                    arm                         = 1'b1;
                end
            end
            lrs_pkg::CMD_NET_DOWN:
            begin
                if (mode_reg != lrs_pkg::LINK_WAIT_NET)
                begin
                    mode_next                = lrs_pkg::LINK_WAIT_NET;
                    st1_next.ctl.notify_code = lrs_pkg::NTF_WAITING;
                end
            end
            lrs_pkg::CMD_SOCK_OPEN:
            begin
                mode_next                      = lrs_pkg::LINK_CONNECTED;
                sess_next                      = 1'b0;
                st1_next.ctl.welcome_timer_cmd = lrs_pkg::TMR_START;
            end
            lrs_pkg::CMD_SOCK_LOST:
            begin
                st1_next.ctl.welcome_timer_cmd = lrs_pkg::TMR_STOP;
                if (mode_reg != lrs_pkg::LINK_WAIT_NET && !drop_reg)
                begin
                    drop_next = 1'b1;
                    if (mode_reg == lrs_pkg::LINK_CONNECTED && sess_reg)
                    begin
                        st1_next.ctl.notify_code = lrs_pkg::NTF_CONNECTING;
                    end
                    mode_next = lrs_pkg::LINK_READY;
                    sess_next = 1'b0;
                    step_next = step_bump;
                    if (fail_inc >= cfg.sock_fail_limit)
                    begin
                        fail_next                  = '0;
                        rcnt_next                  = rcnt_inc;
                        st1_next.ctl.net_reset_req = 1'b1;
                        st1_next.ctl.restart_req   = (rcnt_inc >= cfg.net_reset_limit);
                    end
                    else
                    begin
                        fail_next = fail_inc;
                    end
                    arm = 1'b1;
                end
            end
            lrs_pkg::CMD_WELCOME:
            begin
                if (!sess_reg)
                begin
                    sess_next                      = 1'b1;
                    st1_next.ctl.welcome_timer_cmd = lrs_pkg::TMR_STOP;
                    fail_next                      = '0;
                    rcnt_next                      = '0;
                    step_next                      = '0;
                    st1_next.ctl.notify_code       = lrs_pkg::NTF_READY;
                    st1_next.ctl.flush_outbox      = 1'b1;
                end
            end
            lrs_pkg::CMD_WELCOME_TIMEOUT:
            begin
                if (mode_reg == lrs_pkg::LINK_CONNECTED && !sess_reg)
                begin
                    drop_next                = 1'b1;
                    mode_next                = lrs_pkg::LINK_READY;
                    step_next                = step_bump;
                    st1_next.ctl.notify_code = lrs_pkg::NTF_CONNECTING;
                    arm                      = 1'b1;
                end
            end
            lrs_pkg::CMD_ATTEMPT:
            begin
                st1_next.ctl.close_socket = 1'b1;
                if (mode_reg == lrs_pkg::LINK_READY)
                begin
                    drop_next = 1'b0;
                    if (start_ok_reg)
                    begin
                        st1_next.ctl.open_socket = 1'b1;
                    end
                    else
                    begin
                        step_next = step_bump;
                        arm       = 1'b1;
                    end
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        // The delay uses the backoff level after this event.
        shift_amt = (step_next > lrs_pkg::BACKOFF_CAP) ? lrs_pkg::BACKOFF_CAP : step_next;
        shifted   = {{(lrs_pkg::DELAY_W - lrs_pkg::BASE_W){1'b0}}, cfg.base_delay_us}
                    << shift_amt;
        clipped   = (shifted > cfg.max_delay_us) ? cfg.max_delay_us : shifted;
        jit_mod   = (jitter_reg >= lrs_pkg::JITTER_MOD)
                    ? lrs_pkg::SCALE_W'(jitter_reg - lrs_pkg::JITTER_MOD)
                    : lrs_pkg::SCALE_W'(jitter_reg);

        st1_next.ctl.link_state    = lrs_pkg::link_code(mode_next);
        st1_next.ctl.session_up    = sess_next;
        st1_next.ctl.arm_reconnect = arm;
        st1_next.delay_base        = arm ? clipped : '0;
        st1_next.scale             = lrs_pkg::JITTER_BASE + jit_mod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            st1_valid_reg <= 1'b0;
            mode_reg      <= lrs_pkg::LINK_WAIT_NET;
            sess_reg      <= 1'b0;
            drop_reg      <= 1'b0;
            step_reg      <= '0;
            fail_reg      <= '0;
            rcnt_reg      <= '0;
        end
        else if (advance)
        begin
            evt_valid_reg <= evt.valid;
            st1_valid_reg <= evt_valid_reg;
            if (evt_valid_reg)
            begin
                mode_reg <= mode_next;
                sess_reg <= sess_next;
                drop_reg <= drop_next;
                step_reg <= step_next;
                fail_reg <= fail_next;
                rcnt_reg <= rcnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg      <= lrs_pkg::cmd_t'(evt.command);
            gate_ok_reg  <= evt.gate_ok;
            start_ok_reg <= evt.start_ok;
            jitter_reg   <= evt.jitter;
            st1_reg      <= st1_next;
        end
    end

endmodule

@@ design/lrs_delay.sv @@
// ----------------------------------------------------------------------------
// lrs_delay
// Jitter scaling of the reconnect delay: multiply by the scale, divide by
// 100 through a reciprocal multiply, saturate, and hold the result beat.
// ----------------------------------------------------------------------------
module lrs_delay (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             st1_valid,
    input  lrs_pkg::stage1_t st1,
    output logic             advance,
    lrs_res_if.source        res
);

    localparam int X_W   = lrs_pkg::PROD_W - 2;
    localparam int QF_W  = X_W + lrs_pkg::RECIP_W;
    localparam int QUO_W = QF_W - lrs_pkg::RECIP_SHIFT;

    logic                        st2_valid_reg;
    lrs_pkg::res_ctl_t           ctl2_reg;
    logic [lrs_pkg::PROD_W-1:0]  prod_reg;

    logic                        out_valid_reg;
    lrs_pkg::res_ctl_t           ctl3_reg;
    logic [lrs_pkg::DELAY_W-1:0] delay_reg;

    logic [QF_W-1:0]             quo_full;
    logic [QUO_W-1:0]            quo;
    logic [lrs_pkg::DELAY_W-1:0] delay_next;

    // The whole pipeline moves together whenever the result slot can take a beat.
    assign advance = !out_valid_reg || res.ready;

    assign quo_full   = QF_W'(prod_reg[lrs_pkg::PROD_W-1:2]) * QF_W'(lrs_pkg::RECIP_25);
    assign quo        = quo_full[QF_W-1:lrs_pkg::RECIP_SHIFT];
    assign delay_next = (quo > QUO_W'(lrs_pkg::DELAY_MAX))
                        ? lrs_pkg::DELAY_MAX : quo[lrs_pkg::DELAY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            st2_valid_reg <= st1_valid;
            out_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl2_reg  <= st1.ctl;
            prod_reg  <= lrs_pkg::PROD_W'(st1.delay_base) * lrs_pkg::PROD_W'(st1.scale);
            ctl3_reg  <= ctl2_reg;
            delay_reg <= delay_next;
        end
    end

    assign res.valid              = out_valid_reg;
    assign res.link_state         = ctl3_reg.link_state;
    assign res.session_up         = ctl3_reg.session_up;
    assign res.notify_code        = ctl3_reg.notify_code;
    assign res.arm_reconnect      = ctl3_reg.arm_reconnect;
    assign res.reconnect_delay_us = delay_reg;
    assign res.welcome_timer_cmd  = ctl3_reg.welcome_timer_cmd;
    assign res.gate_timer_cmd     = ctl3_reg.gate_timer_cmd;
    assign res.open_socket        = ctl3_reg.open_socket;
    assign res.close_socket       = ctl3_reg.close_socket;
    assign res.net_reset_req      = ctl3_reg.net_reset_req;
    assign res.restart_req        = ctl3_reg.restart_req;
    assign res.flush_outbox       = ctl3_reg.flush_outbox;

endmodule

@@ design/link_reconnect_supervisor_top.sv @@
// ----------------------------------------------------------------------------
// link_reconnect_supervisor_top
// Link reconnect supervisor: one event in, one result out with the new link
// state, the timer and socket commands and the jittered reconnect delay.
// ----------------------------------------------------------------------------
// An accepted event passes the input, state, product and output registers in order.
// Throughput: one event per cycle; the four-stage pipeline stalls as a whole
// only while a finished result is held back by the sink.
// The link state registers are updated from the input register when the pipeline advances.
// Reset (rst_n low) clears the link state, flags, counters and valid bits and
// loads the register defaults; no clearing pass is needed.
module link_reconnect_supervisor_top (
    input  logic                        clk,
    input  logic                        rst_n,
    lrs_evt_if.sink                     evt,
    lrs_res_if.source                   res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lrs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    lrs_pkg::cfg_t    cfg;
    lrs_pkg::stage1_t st1;
    logic             st1_valid;
    logic             advance;

    lrs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg),
        .evt       (evt),
        .st1_valid (st1_valid),
        .st1       (st1)
    );

    lrs_delay u_delay (
        .clk       (clk),
        .rst_n     (rst_n),
        .st1_valid (st1_valid),
        .st1       (st1),
        .advance   (advance),
        .res       (res)
    );

`ifndef SYNTHESIS
    a_restart_with_reset: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.restart_req |-> res.net_reset_req)
        else $error("restart requested without a network reset");

    a_delay_only_when_armed: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.arm_reconnect |-> res.reconnect_delay_us == 27'd0)
        else $error("reconnect delay given while the timer is not armed");

    a_open_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.open_socket |->
            res.close_socket && res.link_state == lrs_pkg::LS_READY)
        else $error("socket opened outside the ready state");

    a_flush_with_session: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.flush_outbox |->
            res.session_up && res.notify_code == lrs_pkg::NTF_READY)
        else $error("outbox flushed without a ready session");
`endif

endmodule
